// ===== sv/scpr_pkg.sv =====
package scpr_pkg;

  // Default number of page slots in the table.
  localparam int SLOTS_DEF = 16;

  // Fixed field widths.
  localparam int OP_W       = 2;
  localparam int PAGE_W     = 19;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_EVICT  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  // Request payload.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [PAGE_W-1:0]     victim_page;
  } rsp_t;

endpackage

// ===== sv/scpr_stream_if.sv =====
interface scpr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/scpr_ram.sv =====
module scpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/second_chance_page_replacer.sv =====
// Channel  Direction  Payload                                   Transaction
// req      in         operation, page_number                    valid & ready
// rsp      out        status, slot_index, victim_page           valid & ready
//
// One request is processed at a time; the next is taken once the result is in the
// output register. Access scans the page memory one slot per cycle; remove scans
// the same way and then unlinks the slot. Evict passes over referenced pages at the
// head of the queue, clearing their bits and moving them to the tail, and then
// unlinks the head.
// Reset is synchronous and empties the table. A stalled result holds in the output
// register while the block is free to accept the next request.
module second_chance_page_replacer #(
  parameter int SLOTS = scpr_pkg::SLOTS_DEF
) (
  input logic           clk,
  input logic           rst,
  scpr_stream_if.sink   req,
  scpr_stream_if.source rsp
);
  import scpr_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_FIND     = 3'd2;
  localparam logic [2:0] S_EV_CHK   = 3'd3;
  localparam logic [2:0] S_EV_ROT   = 3'd4;
  localparam logic [2:0] S_UNL_RD   = 3'd5;
  localparam logic [2:0] S_UNL_WR   = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]          state;
  logic [OP_W-1:0]     op;
  logic [PAGE_W-1:0]   page;
  logic [SLOTS-1:0]    valid;
  logic [SLOTS-1:0]    refd;
  logic [SLOT_W-1:0]   head;
  logic [SLOT_W-1:0]   tail;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    iter;
  logic [CNT_W-1:0]    scan_idx;
  logic                cmp_vld;
  logic [SLOT_W-1:0]   cmp_idx;
  logic [SLOT_W-1:0]   cur_slot;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [PAGE_W-1:0]   res_victim;
  logic                rsp_valid;
  rsp_t                rsp_data;

  // Memory ports.
  logic                page_we;
  logic [SLOT_W-1:0]   page_waddr;
  logic [PAGE_W-1:0]   page_wdata;
  logic [SLOT_W-1:0]   page_raddr;
  logic [PAGE_W-1:0]   page_rd;
  logic                next_we;
  logic [SLOT_W-1:0]   next_waddr;
  logic [SLOT_W-1:0]   next_wdata;
  logic [SLOT_W-1:0]   next_raddr;
  logic [SLOT_W-1:0]   next_rd;
  logic                prev_we;
  logic [SLOT_W-1:0]   prev_waddr;
  logic [SLOT_W-1:0]   prev_wdata;
  logic [SLOT_W-1:0]   prev_rd;

  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic                ins_ok;
  logic                unl_mid;
  logic                single;
  logic                found;

  // Links read from memory are forced into range.
  function automatic logic [SLOT_W-1:0] clip(input logic [SLOT_W-1:0] s);
    return (CNT_W'(s) < SLOTS_CNT) ? s : '0;
  endfunction

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign ins_ok  = free_found && (count < SLOTS_CNT);
  assign single  = (count <= CNT_W'(1));
  assign unl_mid = !single && (cur_slot != head) && (cur_slot != tail);
  assign found   = cmp_vld && valid[cmp_idx] && (page_rd == page);

  // Page memory: written by insert, read by the scan and by unlink.
  always_comb begin
    page_we    = (state == S_DISPATCH) && (op == OP_INSERT) && ins_ok;
    page_waddr = free_slot;
    page_wdata = page;
    page_raddr = (state == S_FIND) ? scan_idx[SLOT_W-1:0] : cur_slot;
  end

  // Link memories: append on insert and rotation, splice on unlink.
  always_comb begin
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    next_raddr = (state == S_EV_CHK) ? head : cur_slot;
    if (page_we && (count != '0)) begin
      next_we    = 1'b1;
      next_waddr = tail;
      next_wdata = free_slot;
      prev_we    = 1'b1;
      prev_waddr = free_slot;
      prev_wdata = tail;
    end else if (state == S_EV_ROT) begin
      next_we    = 1'b1;
      next_waddr = tail;
      next_wdata = head;
      prev_we    = 1'b1;
      prev_waddr = head;
      prev_wdata = tail;
    end else if ((state == S_UNL_WR) && unl_mid) begin
      next_we    = 1'b1;
      next_waddr = clip(prev_rd);
      next_wdata = next_rd;
      prev_we    = 1'b1;
      prev_waddr = clip(next_rd);
      prev_wdata = prev_rd;
    end
  end

  scpr_ram #(.WIDTH(PAGE_W), .DEPTH(SLOTS)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .raddr (page_raddr),
    .rdata (page_rd)
  );

  scpr_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rd)
  );

  scpr_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (cur_slot),
    .rdata (prev_rd)
  );

  // Sequencer and table control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      refd      <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Output register.
      if ((state == S_DONE) && (!rsp_valid || rsp.ready)) begin
        rsp_valid            <= 1'b1;
        rsp_data.status      <= res_status;
        rsp_data.slot_index  <= SLOT_OUT_W'(res_slot);
        rsp_data.victim_page <= res_victim;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.data.operation;
            page  <= req.data.page_number;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_victim <= '0;
          case (op) inside
            OP_INSERT: begin
              if (ins_ok) begin
                valid[free_slot] <= 1'b1;
                refd[free_slot]  <= 1'b0;
                if (count == '0) begin
                  head <= free_slot;
                end
                tail       <= free_slot;
                count      <= count + CNT_W'(1);
                res_slot   <= free_slot;
                res_status <= ST_OK;
              end else begin
                res_slot   <= '0;
                res_status <= ST_FULL;
              end
              state <= S_DONE;
            end
            OP_ACCESS, OP_REMOVE: begin
              res_slot   <= '0;
              res_status <= ST_OK;
              scan_idx   <= '0;
              cmp_vld    <= 1'b0;
              state      <= S_FIND;
            end
            default: begin
              res_slot <= '0;
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                iter       <= '0;
                state      <= S_EV_CHK;
              end
            end
          endcase
        end
        S_FIND: begin
          // Issue one read per cycle; compare the slot read the cycle before.
          if (scan_idx != SLOTS_CNT) begin
            scan_idx <= scan_idx + CNT_W'(1);
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx[SLOT_W-1:0];
          end else begin
            cmp_vld <= 1'b0;
          end
          if (found) begin
            cur_slot <= cmp_idx;
            if (op == OP_ACCESS) begin
              refd[cmp_idx] <= 1'b1;
              res_slot      <= cmp_idx;
              state         <= S_DONE;
            end else begin
              state <= S_UNL_RD;
            end
          end else if (cmp_vld && (cmp_idx == LAST_SLOT)) begin
            res_status <= ST_MISSING;
            state      <= S_DONE;
          end
        end
        S_EV_CHK: begin
          // A referenced head loses its bit and moves to the tail.
          if ((iter < count) && refd[head]) begin
            refd[head] <= 1'b0;
            iter       <= iter + CNT_W'(1);
            if (!(single || (head == tail))) begin
              state <= S_EV_ROT;
            end
          end else begin
            cur_slot <= head;
            state    <= S_UNL_RD;
          end
        end
        S_EV_ROT: begin
          head  <= clip(next_rd);
          tail  <= head;
          state <= S_EV_CHK;
        end
        S_UNL_RD: begin
          state <= S_UNL_WR;
        end
        S_UNL_WR: begin
          if (single) begin
            head <= '0;
            tail <= '0;
          end else if (cur_slot == head) begin
            head <= clip(next_rd);
          end else if (cur_slot == tail) begin
            tail <= clip(prev_rd);
          end
          valid[cur_slot] <= 1'b0;
          refd[cur_slot]  <= 1'b0;
          if (count != '0) begin
            count <= count - CNT_W'(1);
          end
          res_slot   <= cur_slot;
          res_victim <= (op == OP_EVICT) ? page_rd : '0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
endmodule

// ===== sv/scpr_checker.sv =====
module scpr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [scpr_pkg::STATUS_W-1:0]   rsp_status,
  input logic [scpr_pkg::SLOT_OUT_W-1:0] rsp_slot,
  input logic [scpr_pkg::PAGE_W-1:0]     rsp_victim
);
  import scpr_pkg::*;

  // A stalled result keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
      && $stable(rsp_victim))
    else $error("response changed while stalled");

  // A failed operation reports neither a slot nor a victim.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_slot == '0) && (rsp_victim == '0))
    else $error("failed operation reported a slot or victim");

  // One request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");
endmodule

bind second_chance_page_replacer scpr_checker u_scpr_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.data.status),
  .rsp_slot   (rsp.data.slot_index),
  .rsp_victim (rsp.data.victim_page)
);
